// File: rtl/phc_pkg.sv
// ----------------------------------------------------------------------------
// phc_pkg
// Types and codes shared by the probe header checksum block.
// ----------------------------------------------------------------------------
`default_nettype none

package phc_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    REG_IP_BASE_TCP  = 3'd0,
    REG_IP_BASE_UDP  = 3'd1,
    REG_IP_BASE_SCTP = 3'd2,
    REG_IP_BASE_ICMP = 3'd3,
    REG_IP_BASE_RAW  = 3'd4,
    REG_L4_BASE_TCP  = 3'd5,
    REG_L4_BASE_UDP  = 3'd6
  } cfg_reg_t;

  typedef enum logic [2:0] {
    PCOL_TCP  = 3'd0,
    PCOL_UDP  = 3'd1,
    PCOL_SCTP = 3'd2,
    PCOL_ICMP = 3'd3,
    PCOL_ARP  = 3'd4,
    PCOL_RAW  = 3'd5,
    PCOL_BAD  = 3'd6
  } proto_t;

  localparam logic [1:0] CLASS_TCP = 2'd0;
  localparam logic [1:0] CLASS_UDP = 2'd1;
  localparam logic [1:0] CLASS_SCTP = 2'd2;
  localparam logic [1:0] CLASS_SPECIAL = 2'd3;

  localparam logic [15:0] SPECIAL_ICMP = 16'd0;
  localparam logic [15:0] SPECIAL_ARP = 16'd1;
  localparam logic [15:0] SPECIAL_RAW = 16'd2;
  localparam logic [15:0] SPECIAL_PORT = 16'd1;

  typedef struct packed {
    logic [15:0] ip_base_tcp;
    logic [15:0] ip_base_udp;
    logic [15:0] ip_base_sctp;
    logic [15:0] ip_base_icmp;
    logic [15:0] ip_base_raw;
    logic [15:0] l4_base_tcp;
    logic [15:0] l4_base_udp;
  } cfg_t;

  typedef struct packed {
    logic [31:0] target_addr;
    logic [17:0] port_code;
    logic [31:0] seq_number;
    logic [15:0] payload_sum;
  } probe_t;

  typedef struct packed {
    logic [2:0]  protocol;
    logic [15:0] dest_port;
    logic [15:0] ip_ident;
    logic [15:0] ip_header_sum;
    logic        ip_sum_valid;
    logic [15:0] transport_sum;
    logic        transport_sum_valid;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/phc_cfg_regs.sv
// ----------------------------------------------------------------------------
// phc_cfg_regs
// Template base sum registers written through the configuration port.
// ----------------------------------------------------------------------------
`default_nettype none

module phc_cfg_regs (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write,
  input  wire logic [phc_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [phc_pkg::CfgDataW-1:0]  cfg_data,
  output phc_pkg::cfg_t                      cfg
);

  phc_pkg::cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (cfg_write) begin
      case (phc_pkg::cfg_reg_t'(cfg_index))
        phc_pkg::REG_IP_BASE_TCP:  regs.ip_base_tcp <= cfg_data;
        phc_pkg::REG_IP_BASE_UDP:  regs.ip_base_udp <= cfg_data;
        phc_pkg::REG_IP_BASE_SCTP: regs.ip_base_sctp <= cfg_data;
        phc_pkg::REG_IP_BASE_ICMP: regs.ip_base_icmp <= cfg_data;
        phc_pkg::REG_IP_BASE_RAW:  regs.ip_base_raw <= cfg_data;
        phc_pkg::REG_L4_BASE_TCP:  regs.l4_base_tcp <= cfg_data;
        phc_pkg::REG_L4_BASE_UDP:  regs.l4_base_udp <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

`default_nettype wire

// File: rtl/phc_core.sv
// ----------------------------------------------------------------------------
// phc_core
// Protocol decode, identifier and ones-complement header sums for one word.
// ----------------------------------------------------------------------------
`default_nettype none

module phc_core (
  input  wire phc_pkg::cfg_t    cfg,
  input  wire phc_pkg::probe_t  probe,
  output phc_pkg::result_t      result
);

  logic [1:0]  code_class;
  logic [15:0] code_low;
  logic [2:0]  proto;
  logic [15:0] port;
  logic [15:0] ip_base;
  logic [15:0] l4_base;
  logic [15:0] seq_hi;
  logic [15:0] seq_lo;
  logic [15:0] ident;
  logic [17:0] ip_acc;
  logic [16:0] ip_fold1;
  logic [15:0] ip_fold2;
  logic [18:0] l4_acc;
  logic [16:0] l4_fold1;
  logic [15:0] l4_fold2;
  logic        ip_ok;
  logic        l4_ok;

  assign code_class = probe.port_code[17:16];
  assign code_low = probe.port_code[15:0];

  always_comb begin
    proto = phc_pkg::PCOL_BAD;
    port = '0;
    ip_base = '0;
    case (code_class)
      phc_pkg::CLASS_TCP: begin
        proto = phc_pkg::PCOL_TCP;
        port = code_low;
        ip_base = cfg.ip_base_tcp;
      end
      phc_pkg::CLASS_UDP: begin
        proto = phc_pkg::PCOL_UDP;
        port = code_low;
        ip_base = cfg.ip_base_udp;
      end
      phc_pkg::CLASS_SCTP: begin
        proto = phc_pkg::PCOL_SCTP;
        port = code_low;
        ip_base = cfg.ip_base_sctp;
      end
      default: begin
        if (code_low == phc_pkg::SPECIAL_ICMP) begin
          proto = phc_pkg::PCOL_ICMP;
          port = phc_pkg::SPECIAL_PORT;
          ip_base = cfg.ip_base_icmp;
        end else if (code_low == phc_pkg::SPECIAL_ARP) begin
          proto = phc_pkg::PCOL_ARP;
          port = phc_pkg::SPECIAL_PORT;
        end else if (code_low == phc_pkg::SPECIAL_RAW) begin
          proto = phc_pkg::PCOL_RAW;
          port = phc_pkg::SPECIAL_PORT;
          ip_base = cfg.ip_base_raw;
        end
      end
    endcase
  end

  assign ident = probe.target_addr[15:0] ^ port ^ probe.seq_number[15:0];

  assign ip_acc = {2'b0, ip_base} + {2'b0, ident}
                + {2'b0, probe.target_addr[31:16]} + {2'b0, probe.target_addr[15:0]};
  assign ip_fold1 = {1'b0, ip_acc[15:0]} + {15'b0, ip_acc[17:16]};
  assign ip_fold2 = ip_fold1[15:0] + {15'b0, ip_fold1[16]};

  assign l4_base = (proto == phc_pkg::PCOL_TCP) ? cfg.l4_base_tcp : cfg.l4_base_udp;
  assign seq_hi = (proto == phc_pkg::PCOL_TCP) ? probe.seq_number[31:16] : 16'd0;
  assign seq_lo = (proto == phc_pkg::PCOL_TCP) ? probe.seq_number[15:0] : 16'd0;

  assign l4_acc = {3'b0, probe.payload_sum} + {3'b0, l4_base}
                + {3'b0, probe.target_addr[31:16]} + {3'b0, probe.target_addr[15:0]}
                + {3'b0, port} + {3'b0, seq_hi} + {3'b0, seq_lo};
  assign l4_fold1 = {1'b0, l4_acc[15:0]} + {14'b0, l4_acc[18:16]};
  assign l4_fold2 = l4_fold1[15:0] + {15'b0, l4_fold1[16]};

  assign ip_ok = (proto != phc_pkg::PCOL_ARP) && (proto != phc_pkg::PCOL_BAD);
  assign l4_ok = (proto == phc_pkg::PCOL_TCP) || (proto == phc_pkg::PCOL_UDP);

  always_comb begin
    result.protocol = proto;
    result.dest_port = port;
    result.ip_ident = (proto == phc_pkg::PCOL_BAD) ? 16'd0 : ident;
    result.ip_header_sum = ip_ok ? ~ip_fold2 : 16'd0;
    result.ip_sum_valid = ip_ok;
    result.transport_sum = l4_ok ? ~l4_fold2 : 16'd0;
    result.transport_sum_valid = l4_ok;
  end

endmodule

`default_nettype wire

// File: rtl/probe_header_patch_checksum_top.sv
// ----------------------------------------------------------------------------
// probe_header_patch_checksum_top
// An accepted probe word is held in the input register, then in the result
// register. Throughput: one word per cycle, limited by nothing but result
// stall. Reset: synchronous, clears both stage valids and all template
// base sums to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module probe_header_patch_checksum_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write,
  input  wire logic [phc_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [phc_pkg::CfgDataW-1:0]  cfg_data,
  input  wire logic                          probe_valid,
  output logic                               probe_stall,
  input  wire phc_pkg::probe_t               probe,
  output logic                               result_valid,
  input  wire logic                          result_stall,
  output phc_pkg::result_t                   result
);

  phc_pkg::cfg_t    cfg;
  phc_pkg::probe_t  stage;
  logic             stage_valid;
  phc_pkg::result_t stage_result;
  logic             out_free;
  logic             stage_move;

  phc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  phc_core u_core (
    .cfg    (cfg),
    .probe  (stage),
    .result (stage_result)
  );

  assign out_free = !result_valid || !result_stall;
  assign stage_move = stage_valid && out_free;
  assign probe_stall = stage_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (!probe_stall) begin
        stage_valid <= probe_valid;
      end
      if (out_free) begin
        result_valid <= stage_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (probe_valid && !probe_stall) begin
      stage <= probe;
    end
    if (stage_move) begin
      result <= stage_result;
    end
  end

endmodule

`default_nettype wire
